// ===== hdl/spr_pkg.sv =====
`timescale 1ns / 1ps

package spr_pkg;

    // Widths fixed by the field definitions.
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int TICKS_W = 24;
    localparam int RETRY_W = 8;
    localparam int EVENT_W = 3;
    localparam int NRES_W  = 2;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PORT_ENABLED  = 2'd0,
        REG_CHAR_GAP      = 2'd1,
        REG_DEFAULT_RESP  = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    localparam logic [TICKS_W-1:0] CHAR_GAP_RESET     = 24'd18000;
    localparam logic [TICKS_W-1:0] DEFAULT_RESP_RESET = 24'd100000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_SEND   = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_POLL    = 3'd0,
        EV_SEND    = 3'd1,
        EV_BYTE    = 3'd2,
        EV_FRAME   = 3'd3,
        EV_TIMEOUT = 3'd4
    } event_t;

    typedef enum logic [3:0] {
        PH_REQUESTING = 4'b0001,
        PH_WRITING    = 4'b0010,
        PH_AWAITING   = 4'b0100,
        PH_READING    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic               port_enabled;
        logic [TICKS_W-1:0] char_gap_ticks;
        logic [TICKS_W-1:0] default_response_ticks;
    } cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  byte_out;
        logic               last;
    } result_t;

endpackage

// ===== hdl/spr_core.sv =====
`timescale 1ns / 1ps

module spr_core #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spr_pkg::cfg_t                 cfg,
    input  logic                          fire,
    input  logic [spr_pkg::CMD_W-1:0]     cmd,
    input  logic [spr_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [spr_pkg::TICKS_W-1:0]   response_ticks,
    input  logic [spr_pkg::RETRY_W-1:0]   retry_count,
    output logic [spr_pkg::NRES_W-1:0]    n_res,
    output spr_pkg::result_t              res0,
    output spr_pkg::result_t              res1
);
    import spr_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > TICKS_W) ? TIMER_WIDTH : TICKS_W;

    phase_t                 phase_reg, phase_next;
    logic                   pending_reg, pending_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [TICKS_W-1:0]     active_timeout_reg, active_timeout_next;
    logic [RETRY_W-1:0]     retries_reg, retries_next;

    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic                   resp_expired;
    logic                   gap_expired;

    // Saturating increment and the two threshold compares.
    assign elapsed_inc  = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign resp_expired = CMP_W'(elapsed_inc) >= CMP_W'(active_timeout_reg);
    assign gap_expired  = CMP_W'(elapsed_inc) >= CMP_W'(cfg.char_gap_ticks);

    always_comb
    begin
        phase_next          = phase_reg;
        pending_next        = pending_reg;
        elapsed_next        = elapsed_reg;
        active_timeout_next = active_timeout_reg;
        retries_next        = retries_reg;
        n_res               = '0;
        res0                = '0;
        res1                = '0;

        case (cmd_t'(cmd))
            CMD_SEND:
            begin
                pending_next        = 1'b1;
                active_timeout_next = (response_ticks == '0) ? cfg.default_response_ticks
                                                             : response_ticks;
                retries_next        = retry_count;
            end
            CMD_BYTE:
            begin
                if (phase_reg inside {PH_AWAITING, PH_READING})
                begin
                    n_res          = 2'd1;
                    res0.event_res = EV_BYTE;
                    res0.byte_out  = rx_byte;
                    if (phase_reg == PH_AWAITING)
                    begin
                        pending_next = 1'b0;
                    end
                    phase_next   = PH_READING;
                    elapsed_next = '0;
                end
            end
            CMD_TICK:
            begin
                if (cfg.port_enabled)
                begin
                    case (phase_reg)
                        PH_REQUESTING:
                        begin
                            n_res          = 2'd1;
                            res0.event_res = EV_POLL;
                            phase_next     = PH_WRITING;
                        end
                        PH_WRITING:
                        begin
                            if (pending_reg)
                            begin
                                n_res          = 2'd1;
                                res0.event_res = EV_SEND;
                                elapsed_next   = '0;
                                phase_next     = PH_AWAITING;
                            end
                        end
                        PH_AWAITING:
                        begin
                            elapsed_next = elapsed_inc;
                            if (resp_expired)
                            begin
                                phase_next = PH_WRITING;
                                if (retries_reg != '0)
                                begin
                                    retries_next = retries_reg - 1'b1;
                                end
                                else
                                begin
                                    pending_next   = 1'b0;
                                    n_res          = 2'd2;
                                    res0.event_res = EV_TIMEOUT;
                                    res1.event_res = EV_POLL;
                                end
                            end
                        end
                        PH_READING:
                        begin
                            elapsed_next = elapsed_inc;
                            if (gap_expired)
                            begin
                                n_res          = 2'd2;
                                res0.event_res = EV_FRAME;
                                res1.event_res = EV_POLL;
                                phase_next     = PH_WRITING;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_REQUESTING;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_REQUESTING;
            pending_reg        <= 1'b0;
            elapsed_reg        <= '0;
            active_timeout_reg <= '0;
            retries_reg        <= '0;
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            pending_reg        <= pending_next;
            elapsed_reg        <= elapsed_next;
            active_timeout_reg <= active_timeout_next;
            retries_reg        <= retries_next;
        end
    end

endmodule

// ===== hdl/serial_poll_request_response_sequencer.sv =====
`timescale 1ns / 1ps

// Master-side sequencer for a polled serial request/response link.
// The input channel (in_valid/in_stall) carries one command per beat: a
// 1 us tick, a received byte, or a send request with its response timeout
// and retry count. The output channel (out_valid/out_stall) carries event
// beats: poll request, send frame, forwarded byte, frame complete and
// response timeout. The last beat caused by a command has last set; a
// command can cause zero, one or two beats.
// An accepted command is held in an input register until the sequencer
// logic evaluates it, once the result buffer has room for its beats, and
// those beats enter the buffer, behind any still waiting, the cycle after
// that. Commands that give at most one beat flow at one per cycle while
// the receiver does not stall; a command that gives two beats fills the
// two-entry result buffer, which drains one beat per cycle when not stalled.
// When the receiver stalls, the result buffer holds its beats, the input
// register keeps the pending command and in_stall rises once it cannot
// move; no beat is lost or repeated.
// Reset clears the sequencer to its requesting phase with no frame pending,
// empties both buffers and loads the register defaults: port disabled,
// 18000-tick character gap, 100000-tick timeout. The user must write the
// registers over the APB port only while idle; the block does not check it.

module serial_poll_request_response_sequencer #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [spr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [spr_pkg::CMD_W-1:0]        cmd,
    input  logic [spr_pkg::BYTE_W-1:0]       rx_byte,
    input  logic [spr_pkg::TICKS_W-1:0]      response_ticks,
    input  logic [spr_pkg::RETRY_W-1:0]      retry_count,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [spr_pkg::EVENT_W-1:0]      event_res,
    output logic [spr_pkg::BYTE_W-1:0]       byte_out,
    output logic                             last
);
    import spr_pkg::*;

    // Configuration registers.
    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    // Input register.
    logic                 in_vld_reg, in_vld_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [BYTE_W-1:0]    rx_byte_reg;
    logic [TICKS_W-1:0]   resp_ticks_reg;
    logic [RETRY_W-1:0]   retry_reg;
    logic                 in_acc;

    // Result buffer, two beats deep; entry 0 is the one on the port.
    result_t              slot_reg [2];
    result_t              slot_next [2];
    logic [NRES_W-1:0]    cnt_reg, cnt_next;
    logic [NRES_W-1:0]    cnt_after_pop;
    logic                 out_acc;

    // Sequencer results for the command held in the input register.
    logic [NRES_W-1:0]    n_res;
    result_t              res0, res1;
    logic                 proc;

    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            REG_PORT_ENABLED: prdata = APB_DATA_W'(cfg_reg.port_enabled);
            REG_CHAR_GAP:     prdata = APB_DATA_W'(cfg_reg.char_gap_ticks);
            REG_DEFAULT_RESP: prdata = APB_DATA_W'(cfg_reg.default_response_ticks);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.port_enabled           <= 1'b0;
            cfg_reg.char_gap_ticks         <= CHAR_GAP_RESET;
            cfg_reg.default_response_ticks <= DEFAULT_RESP_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_PORT_ENABLED: cfg_reg.port_enabled           <= pwdata[0];
                REG_CHAR_GAP:     cfg_reg.char_gap_ticks         <= pwdata[TICKS_W-1:0];
                REG_DEFAULT_RESP: cfg_reg.default_response_ticks <= pwdata[TICKS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The held command is evaluated once the result buffer, after this
    // cycle's output beat leaves, has room for every beat it produces.
    assign out_valid     = (cnt_reg != '0);
    assign out_acc       = out_valid && !out_stall;
    assign cnt_after_pop = cnt_reg - NRES_W'(out_acc);
    assign proc          = in_vld_reg
                           && ((3'(cnt_after_pop) + 3'(n_res)) <= 3'd2);
    assign in_stall      = in_vld_reg && !proc;
    assign in_acc        = in_valid && !in_stall;
    assign in_vld_next   = in_acc || (in_vld_reg && !proc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg        <= cmd;
            rx_byte_reg    <= rx_byte;
            resp_ticks_reg <= response_ticks;
            retry_reg      <= retry_count;
        end
    end

    spr_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .fire           (proc),
        .cmd            (cmd_reg),
        .rx_byte        (rx_byte_reg),
        .response_ticks (resp_ticks_reg),
        .retry_count    (retry_reg),
        .n_res          (n_res),
        .res0           (res0),
        .res1           (res1)
    );

    // Pop moves entry 1 forward; new beats are appended behind what is left.
    // Two new beats only arrive into an empty buffer.
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (out_acc)
        begin
            slot_next[0] = slot_reg[1];
        end
        cnt_next = cnt_after_pop;
        if (proc)
        begin
            if (n_res == 2'd2)
            begin
                slot_next[0] = res0;
                slot_next[1] = res1;
            end
            else if (n_res == 2'd1)
            begin
                slot_next[cnt_after_pop[0]] = res0;
            end
            cnt_next = cnt_after_pop + n_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign event_res = slot_reg[0].event_res;
    assign byte_out  = slot_reg[0].byte_out;
    assign last      = slot_reg[0].last;

endmodule

// ===== hdl/spr_checker.sv =====
`timescale 1ns / 1ps

module spr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [spr_pkg::EVENT_W-1:0]   event_res,
    input  logic [spr_pkg::BYTE_W-1:0]    byte_out,
    input  logic                          last
);
    import spr_pkg::*;

    // A stalled beat stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res)
                                   && $stable(byte_out) && $stable(last))
        else $error("output beat changed while stalled");

    // Only a forwarded byte carries byte data.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_BYTE) |-> (byte_out == '0))
        else $error("byte_out nonzero on a non-byte event");

    // A frame-complete or timeout notice is followed at once by the
    // closing poll request of the same command.
    a_notice_poll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (event_res == EV_FRAME || event_res == EV_TIMEOUT)
        |=> out_valid && (event_res == EV_POLL) && last)
        else $error("notice not followed by a final poll request");

    // Notices are never the last beat; byte and send events always are.
    a_notice_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_FRAME || event_res == EV_TIMEOUT) |-> !last)
        else $error("notice marked as last beat");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_BYTE || event_res == EV_SEND) |-> last)
        else $error("single-beat event not marked as last");

endmodule

bind serial_poll_request_response_sequencer spr_checker u_spr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .byte_out  (byte_out),
    .last      (last)
);

// ===== dv/tb_serial_poll_request_response_sequencer.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the serial poll request/response sequencer.
//
// Commands go in as beats on the valid/stall input channel. Events come out as beats
// on the valid/stall output channel. A shadow copy of the sequencer runs inside the
// bench: every command beat that the block accepts is also run through the shadow.
// The events that the shadow produces are queued, and each event beat that the block
// hands over is compared, field by field, with the oldest queued event.
//
// The registers sit behind the APB port. They are only touched once the block has
// gone quiet: every queued event has arrived and a settling wait has passed, which
// lets a trailing command that produces no event clear the pipeline. Each
// register write also updates the shadow's copy of the configuration.

module tb_serial_poll_request_response_sequencer;

    import spr_pkg::*;

    localparam int TIMER_WIDTH = 24;

    // Quiet wait after the last event, so that a command with no event can leave the pipeline.
    localparam int SETTLE_CYCLES = 8;

    // Watchdog limit on the length of a run.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                  clk;
    logic                  rst_n          = 1'b0;

    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      cmd            = '0;
    logic [BYTE_W-1:0]     rx_byte        = '0;
    logic [TICKS_W-1:0]    response_ticks = '0;
    logic [RETRY_W-1:0]    retry_count    = '0;

    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [EVENT_W-1:0]    event_res;
    logic [BYTE_W-1:0]     byte_out;
    logic                  last;

    serial_poll_request_response_sequencer #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .rx_byte       (rx_byte),
        .response_ticks(response_ticks),
        .retry_count   (retry_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .byte_out      (byte_out),
        .last          (last)
    );

    // Shadow copy of the configuration registers. These are the reset defaults.
    logic                   port_on       = 1'b0;
    logic [TICKS_W-1:0]     gap_limit     = CHAR_GAP_RESET;
    logic [TICKS_W-1:0]     default_limit = DEFAULT_RESP_RESET;

    // Shadow copy of the sequencer state.
    phase_t                 seq_phase     = PH_REQUESTING;
    logic                   frame_pending = 1'b0;
    logic [TIMER_WIDTH-1:0] idle_ticks    = '0;
    logic [TICKS_W-1:0]     reply_limit   = '0;
    logic [RETRY_W-1:0]     resends_left  = '0;

    // Events that the shadow has produced and the block has not yet delivered.
    result_t                awaited_events[$];

    int unsigned            mismatches    = 0;
    int unsigned            cycles        = 0;

    // Turns off the sender's random pauses, so that commands arrive back to back.
    bit                     steady_feed   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog. A run that hangs on a handshake ends here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("serial_poll_request_response_sequencer test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow sequencer
    // ------------------------------------------------------------------

    function automatic result_t make_result(event_t ev, logic [BYTE_W-1:0] data);
        result_t r;
        r.event_res = ev;
        r.byte_out  = data;
        r.last      = 1'b0;
        return r;
    endfunction

    // Runs one accepted command through the shadow and queues the events it produces.
    // The final event of a command is marked as last.
    function automatic void advance_sequencer(cmd_t kind, logic [BYTE_W-1:0] data,
                                              logic [TICKS_W-1:0] timeout_ticks,
                                              logic [RETRY_W-1:0] retries);
        result_t produced[$];
        case (kind)
            CMD_SEND:
            begin
                // A send request only loads the frame parameters. The phase does
                // not change, and the port enable does not matter.
                frame_pending = 1'b1;
                reply_limit   = (timeout_ticks == '0) ? default_limit : timeout_ticks;
                resends_left  = retries;
            end
            CMD_BYTE:
            begin
                // Bytes are seen only while a response is awaited or being read.
                if (seq_phase == PH_AWAITING || seq_phase == PH_READING)
                begin
                    produced.push_back(make_result(EV_BYTE, data));
                    if (seq_phase == PH_AWAITING)
                        frame_pending = 1'b0;
                    seq_phase  = PH_READING;
                    idle_ticks = '0;
                end
            end
            CMD_TICK:
            begin
                if (port_on)
                begin
                    case (seq_phase)
                        PH_REQUESTING:
                        begin
                            produced.push_back(make_result(EV_POLL, '0));
                            seq_phase = PH_WRITING;
                        end
                        PH_WRITING:
                        begin
                            if (frame_pending)
                            begin
                                produced.push_back(make_result(EV_SEND, '0));
                                idle_ticks = '0;
                                seq_phase  = PH_AWAITING;
                            end
                        end
                        PH_AWAITING:
                        begin
                            if (idle_ticks != '1)
                                idle_ticks = idle_ticks + 1'b1;
                            if (idle_ticks >= reply_limit)
                            begin
                                // A retry only sends the block back to writing. The
                                // resend itself comes on the next tick.
                                if (resends_left != '0)
                                begin
                                    resends_left = resends_left - 1'b1;
                                    seq_phase    = PH_WRITING;
                                end
                                else
                                begin
                                    frame_pending = 1'b0;
                                    produced.push_back(make_result(EV_TIMEOUT, '0));
                                    produced.push_back(make_result(EV_POLL, '0));
                                    seq_phase = PH_WRITING;
                                end
                            end
                        end
                        default:
                        begin
                            if (idle_ticks != '1)
                                idle_ticks = idle_ticks + 1'b1;
                            if (idle_ticks >= gap_limit)
                            begin
                                produced.push_back(make_result(EV_FRAME, '0));
                                produced.push_back(make_result(EV_POLL, '0));
                                seq_phase = PH_WRITING;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        if (produced.size() > 0)
            produced[produced.size() - 1].last = 1'b1;
        foreach (produced[i])
            awaited_events.push_back(produced[i]);
    endfunction

    // ------------------------------------------------------------------
    // Event checker
    // ------------------------------------------------------------------

    // Outputs are sampled at the clock edge. The bench changes out_stall only with
    // nonblocking assignments at the edge, so the value seen here is the one that the
    // block also sees.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_events.size() == 0)
            begin
                $display("%0t: unexpected event beat, got event_res %0d byte_out %0h last %0b",
                         $time, event_res, byte_out, last);
                mismatches++;
            end
            else
            begin
                want = awaited_events.pop_front();
                if (event_res !== want.event_res)
                begin
                    $display("%0t: event_res mismatch, expected %0d, got %0d",
                             $time, want.event_res, event_res);
                    mismatches++;
                end
                if (byte_out !== want.byte_out)
                begin
                    $display("%0t: byte_out mismatch, expected %0h, got %0h",
                             $time, want.byte_out, byte_out);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // Receiver back-pressure. Short bursts of acceptance alternate with stalls. Most
    // stalls are short and a few are long. Now and then the stall stays off for a long
    // stretch.
    initial
    begin
        int unsigned r;
        forever
        begin
            r = $urandom_range(0, 99);
            out_stall <= 1'b0;
            if (r < 10)
                repeat ($urandom_range(50, 300)) @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 80)
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                else if (r < 97)
                    repeat ($urandom_range(4, 10)) @(posedge clk);
                else
                    repeat ($urandom_range(20, 40)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------

    function automatic int unsigned sender_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_feed || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // Presents one command beat and holds it until the block takes it. Valid stays
    // high into the next beat unless a pause is drawn.
    task automatic issue_command(cmd_t kind, logic [BYTE_W-1:0] data,
                                 logic [TICKS_W-1:0] timeout_ticks,
                                 logic [RETRY_W-1:0] retries);
        int unsigned pause;
        in_valid       <= 1'b1;
        cmd            <= kind;
        rx_byte        <= data;
        response_ticks <= timeout_ticks;
        retry_count    <= retries;
        do
            @(posedge clk);
        while (in_stall);
        advance_sequencer(kind, data, timeout_ticks, retries);
        pause = sender_pause();
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every queued event has arrived. The wait always
    // includes a clock edge, so that valid is never lowered and raised in one time step.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_events.size() != 0);
    endtask

    // The block counts as idle once the last command has also left the pipeline.
    task automatic wait_idle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------

    task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PORT_ENABLED: port_on       = value[0];
            REG_CHAR_GAP:     gap_limit     = value[TICKS_W-1:0];
            REG_DEFAULT_RESP: default_limit = value[TICKS_W-1:0];
            default:
            begin
            end
        endcase
        // The idle wait below keeps psel from being lowered and raised in one time step.
        @(posedge clk);
    endtask

    // Reads a register and compares the bits that the register implements.
    task automatic apb_check(reg_idx_t idx, logic [APB_DATA_W-1:0] want,
                             logic [APB_DATA_W-1:0] mask);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (want & mask))
        begin
            $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
                     $time, idx, want & mask, got & mask);
            mismatches++;
        end
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Checks the reset values of the registers, writes each register and reads it back.
    // A write to the unused index must leave the other registers untouched.
    task automatic test_register_access();
        apb_check(REG_PORT_ENABLED, 32'd0, 32'h1);
        apb_check(REG_CHAR_GAP, {8'd0, CHAR_GAP_RESET}, 32'h00FF_FFFF);
        apb_check(REG_DEFAULT_RESP, {8'd0, DEFAULT_RESP_RESET}, 32'h00FF_FFFF);
        apb_write(REG_PORT_ENABLED, 32'd1);
        apb_write(REG_CHAR_GAP, 32'd2);
        apb_write(REG_DEFAULT_RESP, 32'd3);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        apb_check(REG_PORT_ENABLED, 32'd1, 32'h1);
        apb_check(REG_CHAR_GAP, 32'd2, 32'h00FF_FFFF);
        apb_check(REG_DEFAULT_RESP, 32'd3, 32'h00FF_FFFF);
    endtask

    // Walks one frame through poll, send, reception and the character gap. Along the
    // way, a byte outside a response and the unused command code must be ignored.
    task automatic test_poll_send_and_frame();
        issue_command(CMD_BYTE, 8'hA5, 24'd0, 8'd0);
        issue_command(CMD_RSVD, 8'h5A, 24'hFFFFFF, 8'hFF);
        issue_command(CMD_SEND, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_BYTE, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_BYTE, 8'hFF, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
    endtask

    // A send request that arrives while a response is awaited overwrites the timeout and
    // the retry count. One retry then resends the frame, and the second expiry reports
    // a timeout followed by a fresh poll.
    task automatic test_retry_and_timeout();
        issue_command(CMD_SEND, 8'h00, 24'hFFFFFF, 8'hFF);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_SEND, 8'h00, 24'd1, 8'd1);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
    endtask

    // With the port disabled, ticks do nothing. Send requests and bytes are still
    // handled as usual.
    task automatic test_disabled_port();
        issue_command(CMD_SEND, 8'h00, 24'd5, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        wait_idle();
        apb_write(REG_PORT_ENABLED, 32'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_SEND, 8'h00, 24'd0, 8'd3);
        issue_command(CMD_BYTE, 8'h3C, 24'd0, 8'd0);
        wait_idle();
        apb_write(REG_PORT_ENABLED, 32'd1);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
    endtask

    // A zero timeout and a zero gap expire on the first tick. At the largest register
    // values, neither one expires within a few ticks.
    task automatic test_threshold_extremes();
        wait_idle();
        apb_write(REG_CHAR_GAP, 32'd0);
        apb_write(REG_DEFAULT_RESP, 32'd0);
        issue_command(CMD_SEND, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_SEND, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_BYTE, 8'h81, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        wait_idle();
        apb_write(REG_CHAR_GAP, 32'h00FF_FFFF);
        apb_write(REG_DEFAULT_RESP, 32'h00FF_FFFF);
        issue_command(CMD_SEND, 8'h00, 24'd0, 8'hFF);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        issue_command(CMD_BYTE, 8'h7E, 24'd0, 8'd0);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
        wait_idle();
        // Shrinking the gap lets the next tick close the frame.
        apb_write(REG_CHAR_GAP, 32'd1);
        issue_command(CMD_TICK, 8'h00, 24'd0, 8'd0);
    endtask

    // Chooses the next command from the shadow's phase. Most traffic follows the
    // protocol: a send request when nothing is pending, ticks to move the sequence on,
    // and bursts of bytes while a response is awaited or read. The rest is noise.
    function automatic cmd_t pick_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (seq_phase)
            PH_REQUESTING:
                if (r < 85)      return CMD_TICK;
                else if (r < 92) return CMD_SEND;
                else if (r < 97) return CMD_BYTE;
                else             return CMD_RSVD;
            PH_WRITING:
                if (!frame_pending && r < 60) return CMD_SEND;
                else if (r < 90)              return CMD_TICK;
                else if (r < 96)              return CMD_BYTE;
                else                          return CMD_RSVD;
            PH_AWAITING:
                if (r < 60)      return CMD_TICK;
                else if (r < 92) return CMD_BYTE;
                else if (r < 97) return CMD_SEND;
                else             return CMD_RSVD;
            default:
                if (r < 70)      return CMD_TICK;
                else if (r < 95) return CMD_BYTE;
                else if (r < 98) return CMD_SEND;
                else             return CMD_RSVD;
        endcase
    endfunction

    // Timeouts are mostly short so that they expire often. Some are zero and select
    // the default, and a few are full-range values.
    function automatic logic [TICKS_W-1:0] pick_timeout();
        int unsigned        r;
        logic [TICKS_W-1:0] v;
        r = $urandom_range(0, 99);
        v = TICKS_W'($urandom);
        if (r < 10)
            v = '0;
        else if (r >= 20)
            v = TICKS_W'($urandom_range(1, 8));
        return v;
    endfunction

    function automatic logic [RETRY_W-1:0] pick_retries();
        if ($urandom_range(0, 99) < 75)
            return RETRY_W'($urandom_range(0, 3));
        else
            return RETRY_W'($urandom_range(0, 255));
    endfunction

    // One phase of random traffic under one register setting. Reserved codes, ticks
    // with the port off and bytes outside a response do not count toward the phase
    // length. The try limit keeps a phase with the port off from spinning forever.
    task automatic run_random_phase(logic enable, logic [TICKS_W-1:0] gap,
                                    logic [TICKS_W-1:0] dflt, int unsigned items,
                                    bit steady);
        int unsigned done;
        int unsigned tries;
        cmd_t        kind;
        wait_idle();
        apb_write(REG_PORT_ENABLED, {31'd0, enable});
        apb_write(REG_CHAR_GAP, {8'd0, gap});
        apb_write(REG_DEFAULT_RESP, {8'd0, dflt});
        steady_feed = steady;
        done  = 0;
        tries = 0;
        while (done < items && tries < 4 * items)
        begin
            tries++;
            // Now and then, the sender holds off until the output side has drained.
            if ($urandom_range(0, 149) == 0)
                wait_for_results();
            kind = pick_command();
            if (!(kind == CMD_RSVD ||
                  (kind == CMD_TICK && !port_on) ||
                  (kind == CMD_BYTE && seq_phase != PH_AWAITING &&
                   seq_phase != PH_READING)))
                done++;
            issue_command(kind, BYTE_W'($urandom_range(0, 255)), pick_timeout(),
                          pick_retries());
        end
        steady_feed = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b1, 24'd3, 24'd4, 300, 1'b0);
        run_random_phase(1'b1, 24'd1, 24'd1, 300, 1'b1);
        run_random_phase(1'b1, TICKS_W'($urandom_range(2, 8)),
                         TICKS_W'($urandom_range(2, 12)), 300, 1'b0);
        run_random_phase(1'b0, 24'd2, 24'd3, 60, 1'b0);
        // With the largest default, a zero timeout waits until a byte arrives.
        run_random_phase(1'b1, 24'd5, 24'hFFFFFF, 340, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_poll_send_and_frame();
        test_retry_and_timeout();
        test_disabled_port();
        test_threshold_extremes();
        test_random_traffic();

        // Wait for the last events to arrive. The extra quiet cycles also let any
        // stray beat that follows reach the checker.
        wait_idle();
        if (mismatches == 0)
            $display("serial_poll_request_response_sequencer test passed");
        else
            $display("serial_poll_request_response_sequencer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/spr_pkg.sv
hdl/spr_core.sv
hdl/serial_poll_request_response_sequencer.sv
hdl/spr_checker.sv
dv/tb_serial_poll_request_response_sequencer.sv
